// ===== rtl/dtu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtu_pkg
// Shared types, constants and tables of the decimal-with-unit parser.
// ----------------------------------------------------------------------------
package dtu_pkg;

  localparam int unsigned FRAC_MAX  = 9;
  localparam int unsigned NUM_W     = 70;
  localparam int unsigned DEN_W     = 30;
  localparam int unsigned DIV_CNT_W = $clog2(NUM_W);

  typedef enum logic [1:0] {
    PH_INT  = 2'd0,
    PH_FRAC = 2'd1,
    PH_SUF  = 2'd2,
    PH_SPR  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    SUF_NONE = 3'd0,
    SUF_B    = 3'd1,
    SUF_LET  = 3'd2,
    SUF_I    = 3'd3,
    SUF_IB   = 3'd4,
    SUF_BAD  = 3'd5
  } suf_t;

  typedef enum logic [2:0] {
    S_PARSE  = 3'd0,
    S_MUL0   = 3'd1,
    S_MUL1   = 3'd2,
    S_MUL2   = 3'd3,
    S_DSTART = 3'd4,
    S_DIV    = 3'd5,
    S_FIN    = 3'd6
  } state_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic take;
    logic mul0;
    logic mul1;
    logic mul2;
    logic div_start;
    logic finish;
  } dtu_cmd_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic div_done;
  } dtu_sts_t;

  // Powers of ten for the fraction denominator
  function automatic logic [DEN_W-1:0] pow10(input logic [3:0] n);
    case (n)
      4'd1:    pow10 = DEN_W'(10);
      4'd2:    pow10 = DEN_W'(100);
      4'd3:    pow10 = DEN_W'(1000);
      4'd4:    pow10 = DEN_W'(10000);
      4'd5:    pow10 = DEN_W'(100000);
      4'd6:    pow10 = DEN_W'(1000000);
      4'd7:    pow10 = DEN_W'(10000000);
      4'd8:    pow10 = DEN_W'(100000000);
      4'd9:    pow10 = DEN_W'(1000000000);
      default: pow10 = DEN_W'(1);
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== rtl/dtu_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtu_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dtu_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [dtu_pkg::NUM_W-1:0] num,
  input  wire logic [dtu_pkg::DEN_W-1:0] den,
  output logic                           done,
  output logic [dtu_pkg::NUM_W-1:0]      quot
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [dtu_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [dtu_pkg::NUM_W-1:0]     num_r, num_nxt;
  logic [dtu_pkg::DEN_W-1:0]     rem_r, rem_nxt;
  logic [dtu_pkg::DEN_W-1:0]     den_r, den_nxt;
  logic [dtu_pkg::DEN_W:0]       rem_s;
  logic                          fits;

  // One shift-subtract step; quotient bits enter at the bottom
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    rem_s    = {rem_r, num_r[dtu_pkg::NUM_W-1]};
    fits     = rem_s >= {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = fits ? dtu_pkg::DEN_W'(rem_s - {1'b0, den_r})
                     : rem_s[dtu_pkg::DEN_W-1:0];
      num_nxt = {num_r[dtu_pkg::NUM_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == dtu_pkg::DIV_CNT_W'(dtu_pkg::NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = num_r;

endmodule
`default_nettype wire

// ===== rtl/dtu_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtu_dp
// Parse registers, unit decode, scaling multiplies and result register.
// ----------------------------------------------------------------------------
module dtu_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dtu_pkg::dtu_cmd_t cmd,
  output dtu_pkg::dtu_sts_t      sts,
  input  wire logic [7:0]        char_code,
  input  wire logic              last,
  input  wire logic              mode,
  output logic [63:0]            scaled_value,
  output logic                   ok
);

  localparam logic [63:0] LIM_DUR = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM_SZ  = 64'hFFFF_FFFF_FFFF_FFFF;

  logic [63:0]          whole_r, whole_nxt;
  logic [29:0]          frac_r, frac_nxt;
  logic [3:0]           fcnt_r, fcnt_nxt;
  dtu_pkg::phase_t      phase_r, phase_nxt;
  logic                 seen_r, seen_nxt;
  logic                 over_r, over_nxt;
  logic                 bad_r, bad_nxt;
  dtu_pkg::suf_t        suf_r, suf_nxt;
  logic [2:0]           unit_r, unit_nxt;

  logic                 dur_r, pre_ok_r;
  logic [5:0]           shamt_r;
  logic [19:0]          dmul_r;
  logic [51:0]          plo_r, phi_r;
  logic [103:0]         prod_r;
  logic [69:0]          fnum_r;
  logic [63:0]          res_r;
  logic                 ok_r;

  logic [67:0]          t10;
  logic [63:0]          lim;
  logic [3:0]           dval;
  logic                 digit;
  logic                 mult_ok;
  logic [5:0]           shamt;
  logic [19:0]          dmul;
  logic [69:0]          quot;
  logic [64:0]          sum;
  logic                 fin_ok;

  // Suffix recognizer step
  function automatic void track(input logic [7:0] c, inout dtu_pkg::suf_t s,
                                inout logic [2:0] u);
    case (s)
      dtu_pkg::SUF_NONE: begin
        case (c)
          "B":     begin s = dtu_pkg::SUF_B;   u = 3'd0; end
          "K":     begin s = dtu_pkg::SUF_LET; u = 3'd1; end
          "M":     begin s = dtu_pkg::SUF_LET; u = 3'd2; end
          "G":     begin s = dtu_pkg::SUF_LET; u = 3'd3; end
          "T":     begin s = dtu_pkg::SUF_LET; u = 3'd4; end
          default: s = dtu_pkg::SUF_BAD;
        endcase
      end
      dtu_pkg::SUF_LET: s = (c == "i") ? dtu_pkg::SUF_I : dtu_pkg::SUF_BAD;
      dtu_pkg::SUF_I:   s = (c == "B") ? dtu_pkg::SUF_IB : dtu_pkg::SUF_BAD;
      default:          s = dtu_pkg::SUF_BAD;
    endcase
  endfunction

  // Apply one character to the parse registers
  always_comb begin
    whole_nxt = whole_r;
    frac_nxt  = frac_r;
    fcnt_nxt  = fcnt_r;
    phase_nxt = phase_r;
    seen_nxt  = seen_r;
    over_nxt  = over_r;
    bad_nxt   = bad_r;
    suf_nxt   = suf_r;
    unit_nxt  = unit_r;
    dval      = char_code[3:0];
    digit     = (char_code >= "0") && (char_code <= "9");
    lim       = mode ? LIM_DUR : LIM_SZ;
    t10       = {whole_r, 3'b000} + {2'b00, whole_r, 1'b0} + 68'(dval);
    if (phase_r == dtu_pkg::PH_SUF || phase_r == dtu_pkg::PH_SPR) begin
      track(char_code, suf_nxt, unit_nxt);
    end else if (digit) begin
      seen_nxt = 1'b1;
      if (phase_r == dtu_pkg::PH_INT) begin
        if (t10 > {4'b0000, lim}) over_nxt = 1'b1;
        else whole_nxt = t10[63:0];
      end else if (fcnt_r < 4'(dtu_pkg::FRAC_MAX)) begin
        frac_nxt = 30'({frac_r, 3'b000} + {2'b00, frac_r, 1'b0} + 33'(dval));
        fcnt_nxt = fcnt_r + 1'b1;
      end
    end else if (char_code == ".") begin
      if (phase_r == dtu_pkg::PH_INT) phase_nxt = dtu_pkg::PH_FRAC;
      else bad_nxt = 1'b1;
    end else if (!mode) begin
      phase_nxt = dtu_pkg::PH_SUF;
      track(char_code, suf_nxt, unit_nxt);
    end else begin
      bad_nxt = 1'b1;
    end
  end

  // Decode the unit on the final character
  always_comb begin
    mult_ok = 1'b0;
    shamt   = 6'd0;
    dmul    = 20'd0;
    if (!mode) begin
      if ((suf_nxt == dtu_pkg::SUF_NONE || suf_nxt == dtu_pkg::SUF_B ||
           suf_nxt == dtu_pkg::SUF_LET || suf_nxt == dtu_pkg::SUF_IB) &&
          unit_nxt <= 3'd4) begin
        mult_ok = 1'b1;
        shamt   = 6'(unit_nxt) * 6'd10;
      end
    end else if (phase_r == dtu_pkg::PH_INT || phase_r == dtu_pkg::PH_FRAC) begin
      mult_ok = 1'b1;
      case (char_code)
        "s":     dmul = 20'd1;
        "m":     dmul = 20'd60;
        "h":     dmul = 20'd3600;
        "d":     dmul = 20'd86400;
        "w":     dmul = 20'd604800;
        default: mult_ok = 1'b0;
      endcase
    end
  end

  // Parse registers: advance on each character but a duration token's last, clear after a result
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.finish) begin
      whole_r <= '0;
      frac_r  <= '0;
      fcnt_r  <= '0;
      phase_r <= dtu_pkg::PH_INT;
      seen_r  <= 1'b0;
      over_r  <= 1'b0;
      bad_r   <= 1'b0;
      suf_r   <= dtu_pkg::SUF_NONE;
      unit_r  <= 3'd0;
    end else if (cmd.take && !(last && mode)) begin
      whole_r <= whole_nxt;
      frac_r  <= frac_nxt;
      fcnt_r  <= fcnt_nxt;
      phase_r <= phase_nxt;
      seen_r  <= seen_nxt;
      over_r  <= over_nxt;
      bad_r   <= bad_nxt;
      suf_r   <= suf_nxt;
      unit_r  <= unit_nxt;
    end
  end

  // Latch the unit and the early verdict on the final character
  always_ff @(posedge clk) begin
    if (cmd.take && last) begin
      dur_r    <= mode;
      shamt_r  <= shamt;
      dmul_r   <= dmul;
      pre_ok_r <= mult_ok &&
                  (mode ? (seen_r && !bad_r && !over_r)
                        : (seen_nxt && !bad_nxt && !over_nxt));
    end
  end

  // Scale: split 64x20 product (duration) or shift (size), and fraction numerator
  always_ff @(posedge clk) begin
    if (cmd.mul0) plo_r <= whole_r[31:0] * dmul_r;
    if (cmd.mul1) phi_r <= whole_r[63:32] * dmul_r;
    if (cmd.mul2) begin
      if (dur_r) begin
        prod_r <= {52'd0, plo_r} + {20'd0, phi_r, 32'd0};
        fnum_r <= {20'd0, 50'(frac_r) * 50'(dmul_r)};
      end else begin
        prod_r <= {40'd0, whole_r} << shamt_r;
        fnum_r <= {40'd0, frac_r} << shamt_r;
      end
    end
  end

  dtu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (fnum_r),
    .den   (dtu_pkg::pow10(fcnt_r)),
    .done  (sts.div_done),
    .quot  (quot)
  );

  // Final sum and limit checks
  always_comb begin
    sum    = {1'b0, prod_r[63:0]} + {24'd0, quot[40:0]};
    fin_ok = pre_ok_r && (prod_r[103:64] == 40'd0) && !sum[64] &&
             !(dur_r && sum[63]);
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_r <= fin_ok ? sum[63:0] : 64'd0;
      ok_r  <= fin_ok;
    end
  end

  assign scaled_value = res_r;
  assign ok           = ok_r;

endmodule
`default_nettype wire

// ===== rtl/dtu_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtu_ctrl
// Sequencer: per-character parse, then multiply, divide and result hand-off.
// ----------------------------------------------------------------------------
module dtu_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_last,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output dtu_pkg::dtu_cmd_t      cmd,
  input  wire dtu_pkg::dtu_sts_t sts
);

  dtu_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dtu_pkg::S_PARSE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    slot_free = !out_valid_r || !out_stall;
    case (state_r)
      dtu_pkg::S_PARSE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
        if (in_valid && in_last) state_nxt = dtu_pkg::S_MUL0;
      end
      dtu_pkg::S_MUL0: begin
        cmd.mul0  = 1'b1;
        state_nxt = dtu_pkg::S_MUL1;
      end
      dtu_pkg::S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = dtu_pkg::S_MUL2;
      end
      dtu_pkg::S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = dtu_pkg::S_DSTART;
      end
      dtu_pkg::S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = dtu_pkg::S_DIV;
      end
      dtu_pkg::S_DIV: begin
        if (sts.div_done) state_nxt = dtu_pkg::S_FIN;
      end
      dtu_pkg::S_FIN: begin
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = dtu_pkg::S_PARSE;
        end
      end
      default: state_nxt = dtu_pkg::S_PARSE;
    endcase
    out_valid_nxt = (out_valid_r && out_stall) || cmd.finish;
  end

  assign out_valid = out_valid_r;

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last) |=> state_r == dtu_pkg::S_MUL0)
    else $error("final item did not start scaling");
  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dtu_pkg::S_DIV && sts.div_done) |=> state_r == dtu_pkg::S_FIN)
    else $error("divide completion missed");
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (out_valid_r && state_r == dtu_pkg::S_PARSE))
    else $error("result not presented");

endmodule
`default_nettype wire

// ===== rtl/decimal_with_unit_to_integer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_with_unit_to_integer
// Streaming parser of a decimal number with a size or duration unit suffix.
// ----------------------------------------------------------------------------
// A token enters one character per item; every character but the last is
// taken without a stall. The last character starts scaling: the multiply
// states S_MUL0, S_MUL1 and S_MUL2, then a bit-serial divide of the
// fraction by its power of ten, then the result is loaded into the output
// register; the input stalls until then. The output register lets the
// next token start while a result waits to be taken.
module decimal_with_unit_to_integer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_char_code,
  input  wire logic        in_last,
  input  wire logic        in_mode,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_scaled_value,
  output logic             out_ok
);

  dtu_pkg::dtu_cmd_t cmd;
  dtu_pkg::dtu_sts_t sts;

  dtu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  dtu_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .char_code    (in_char_code),
    .last         (in_last),
    .mode         (in_mode),
    .scaled_value (out_scaled_value),
    .ok           (out_ok)
  );

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the decimal-with-unit parser. A directed table
// of tokens, some with typed results, comes first, then random tokens in
// size and duration mode (well-formed numbers with units, long and
// overflowing values, broken syntax and byte noise) under several idle and
// stall mixes. Untyped results come from an in-bench model of the parser.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RAND_ITEMS     = 600;

  typedef struct {
    bit [63:0] value;
    bit        ok;
  } parse_res_t;

  typedef struct {
    bit [7:0] ch;
    bit       md;
  } tok_char_t;

  // typed rows carry their result; the others go to the model
  typedef struct {
    string     txt;
    bit        md;
    bit [63:0] value;
    bit        ok;
    bit        typed;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_code = 8'd0;
  logic        in_last = 1'b0;
  logic        in_mode = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_scaled_value;
  logic        out_ok;

  // parser model state
  bit [63:0]       whole_acc;
  bit [31:0]       frac_acc;
  bit [3:0]        frac_cnt;
  dtu_pkg::phase_t ph;
  bit              seen_dig, over_f, bad_f;
  dtu_pkg::suf_t   suf;
  bit [2:0]        unit;

  parse_res_t result_q[$];
  dir_row_t   typed_q[$];
  tok_char_t  tok_q[$];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold = 0;
  int err_cnt = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  int tokens_ok = 0;
  int tokens_rej = 0;

  dir_row_t dir_tab[11] = '{
    '{"0",    1'b0, 64'd0,             1'b1, 1'b1},
    '{"1.5K", 1'b0, 64'd1536,          1'b1, 1'b0},
    '{"1TiB", 1'b0, 64'd1099511627776, 1'b1, 1'b1},
    '{"s",    1'b1, 64'd0,             1'b0, 1'b1},
    '{"2w",   1'b1, 64'd1209600,       1'b1, 1'b0},
    '{"1..2", 1'b0, 64'd0,             1'b0, 1'b1},
    '{"3x",   1'b1, 64'd0,             1'b0, 1'b1},
    '{"5Q",   1'b0, 64'd0,             1'b0, 1'b1},
    '{".",    1'b0, 64'd0,             1'b0, 1'b1},
    '{"1h",   1'b1, 64'd3600,          1'b1, 1'b0},
    '{"1m",   1'b1, 64'd60,            1'b1, 1'b0}
  };

  decimal_with_unit_to_integer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .in_last          (in_last),
    .in_mode          (in_mode),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_scaled_value (out_scaled_value),
    .out_ok           (out_ok)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- model
  function automatic bit [63:0] mode_limit(bit md);
    return md ? 64'h7FFF_FFFF_FFFF_FFFF : 64'hFFFF_FFFF_FFFF_FFFF;
  endfunction

  function automatic bit [63:0] ten_pow(bit [3:0] n);
    bit [63:0] p;
    p = 64'd1;
    if (n <= 4'd9) begin
      for (int i = 0; i < n; i++) p = p * 10;
    end
    return p;
  endfunction

  function automatic void clear_parse();
    whole_acc = '0;
    frac_acc = '0;
    frac_cnt = '0;
    ph = dtu_pkg::PH_INT;
    seen_dig = 1'b0;
    over_f = 1'b0;
    bad_f = 1'b0;
    suf = dtu_pkg::SUF_NONE;
    unit = '0;
  endfunction

  function automatic void track_unit(bit [7:0] c);
    case (suf)
      dtu_pkg::SUF_NONE: begin
        suf = dtu_pkg::SUF_LET;
        case (c)
          "B": begin suf = dtu_pkg::SUF_B; unit = 3'd0; end
          "K": unit = 3'd1;
          "M": unit = 3'd2;
          "G": unit = 3'd3;
          "T": unit = 3'd4;
          default: suf = dtu_pkg::SUF_BAD;
        endcase
      end
      dtu_pkg::SUF_LET: suf = (c == "i") ? dtu_pkg::SUF_I : dtu_pkg::SUF_BAD;
      dtu_pkg::SUF_I:   suf = (c == "B") ? dtu_pkg::SUF_IB : dtu_pkg::SUF_BAD;
      default:          suf = dtu_pkg::SUF_BAD;
    endcase
  endfunction

  function automatic void take_char(bit [7:0] c, bit md);
    bit [63:0] d, lim;
    if (ph == dtu_pkg::PH_SUF || ph == dtu_pkg::PH_SPR) begin
      track_unit(c);
      return;
    end
    if (c >= "0" && c <= "9") begin
      d = 64'(c - 8'h30);
      seen_dig = 1'b1;
      if (ph == dtu_pkg::PH_INT) begin
        lim = mode_limit(md);
        if (whole_acc > (lim - d) / 10) over_f = 1'b1;
        else whole_acc = whole_acc * 10 + d;
      end else if (frac_cnt < dtu_pkg::FRAC_MAX) begin
        frac_acc = frac_acc * 10 + 32'(d);
        frac_cnt = frac_cnt + 4'd1;
      end
    end else if (c == ".") begin
      if (ph == dtu_pkg::PH_INT) ph = dtu_pkg::PH_FRAC;
      else bad_f = 1'b1;
    end else if (!md) begin
      ph = dtu_pkg::PH_SUF;
      track_unit(c);
    end else begin
      bad_f = 1'b1;
    end
  endfunction

  // scale the parsed number; ok only when within the limit
  function automatic parse_res_t scale_number(bit [63:0] mult, bit [63:0] lim);
    parse_res_t r;
    bit [63:0] den, frac, base, q, rm, extra, rest;
    r = '{64'd0, 1'b0};
    den = ten_pow(frac_cnt);
    frac = 64'(frac_acc);
    if (!seen_dig || bad_f || over_f || mult == 0) return r;
    if (whole_acc > lim / mult) return r;
    base = whole_acc * mult;
    q = mult / den;
    rm = mult % den;
    if (q != 0 && frac > lim / q) return r;
    extra = frac * q;
    rest = (frac * rm) / den;
    if (rest > lim - extra || extra + rest > lim - base) return r;
    r = '{base + extra + rest, 1'b1};
    return r;
  endfunction

  function automatic void predict_char(bit [7:0] c, bit lst, bit md);
    bit [63:0] mult;
    parse_res_t r;
    dir_row_t t;
    mult = 64'd0;
    if (!lst) begin
      take_char(c, md);
      return;
    end
    if (!md) begin
      take_char(c, 1'b0);
      if (suf inside {dtu_pkg::SUF_NONE, dtu_pkg::SUF_B, dtu_pkg::SUF_LET,
                      dtu_pkg::SUF_IB})
        mult = (unit <= 3'd4) ? (64'd1 << (10 * unit)) : 64'd1;
    end else if (ph == dtu_pkg::PH_INT || ph == dtu_pkg::PH_FRAC) begin
      case (c)
        "s": mult = 64'd1;
        "m": mult = 64'd60;
        "h": mult = 64'd3600;
        "d": mult = 64'd86400;
        "w": mult = 64'd604800;
        default: mult = 64'd0;
      endcase
    end
    r = scale_number(mult, mode_limit(md));
    // typed directed rows carry their own result
    if (typed_q.size() != 0) begin
      t = typed_q.pop_front();
      if (t.typed) r = '{t.value, t.ok};
    end
    result_q.push_back(r);
    clear_parse();
  endfunction

  // ------------------------------------------------------- monitor, check
  always @(posedge clk) begin
    parse_res_t e;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
      if (in_valid && !in_stall) predict_char(in_char_code, in_last, in_mode);
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("unexpected result value=%0d ok=%0b", out_scaled_value, out_ok);
          err_cnt++;
        end else begin
          e = result_q.pop_front();
          if (out_scaled_value !== e.value) begin
            $error("scaled_value exp=%0d act=%0d", e.value, out_scaled_value);
            err_cnt++;
          end
          if (out_ok !== e.ok) begin
            $error("ok exp=%0b act=%0b", e.ok, out_ok);
            err_cnt++;
          end
          if (out_ok === 1'b1) tokens_ok++;
          else tokens_rej++;
        end
      end
    end
  end

  // receiver: long hold when asked, else random stall
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_stall <= 1'b1;
      rx_hold <= rx_hold - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // ---------------------------------------------------------------- sender
  task automatic send_item(bit [7:0] c, bit lst, bit md);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    in_last <= lst;
    in_mode <= md;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_token();
    for (int i = 0; i < tok_q.size(); i++)
      send_item(tok_q[i].ch, i == tok_q.size() - 1, tok_q[i].md);
    tok_q.delete();
  endtask

  function automatic void add_text(string s, bit md);
    for (int i = 0; i < s.len(); i++) tok_q.push_back('{s[i], md});
  endfunction

  function automatic void add_digits(int n, bit md);
    for (int i = 0; i < n; i++) tok_q.push_back('{8'h30 + 8'($urandom_range(9)), md});
  endfunction

  // build one random token: mostly well-formed, some broken, some noise
  function automatic void build_token();
    string size_units[14] = '{"", "B", "K", "KiB", "M", "MiB", "G", "GiB",
                              "T", "TiB", "Ki", "KB", "iB", "k"};
    string dur_units[6] = '{"s", "m", "h", "d", "w", "x"};
    string big_vals[4] = '{"18446744073709551615", "18446744073709551616",
                           "9223372036854775807", "9223372036854775808"};
    bit md;
    int kind, k;
    md = $urandom_range(1);
    kind = $urandom_range(99);
    if (kind < 10) begin
      // random bytes with mixed modes
      k = $urandom_range(1, 6);
      for (int i = 0; i < k; i++)
        tok_q.push_back('{8'($urandom_range(255)), 1'($urandom_range(1))});
      return;
    end
    if (kind < 20) add_text(big_vals[$urandom_range(3)], md);
    else add_digits(($urandom_range(9) == 0) ? $urandom_range(10, 20)
                                             : $urandom_range(0, 6), md);
    if ($urandom_range(2) == 0) begin
      add_text(".", md);
      add_digits($urandom_range(0, 12), md);
    end
    if (kind >= 20 && kind < 28) add_text(".", md);
    if (md) add_text(dur_units[$urandom_range(5)], md);
    else add_text(size_units[$urandom_range(13)], md);
    if (!md && kind >= 28 && kind < 33) add_digits(1, md);
    // flip one byte's mode now and then
    if (kind >= 33 && kind < 38) begin
      k = $urandom_range(tok_q.size() - 1);
      tok_q[k].md = ~tok_q[k].md;
    end
  endfunction

  // ----------------------------------------------------------------- main
  initial begin
    int phase_pct[4][2] = '{'{0, 0}, '{54, 0}, '{0, 54}, '{14, 14}};
    int goal;
    clear_parse();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_tab[r]) begin
      add_text(dir_tab[r].txt, dir_tab[r].md);
      typed_q.push_back(dir_tab[r]);
      send_token();
    end
    in_valid <= 1'b0;
    wait (result_q.size() == 0);

    // random phases
    for (int p = 0; p < 4; p++) begin
      tx_idle_pct = phase_pct[p][0];
      rx_stall_pct = phase_pct[p][1];
      if (p == 0) rx_hold = 400;
      goal = items_sent + RAND_ITEMS / 4;
      while (items_sent < goal) begin
        build_token();
        send_token();
      end
      // hold the sender until every result is back
      in_valid <= 1'b0;
      wait (result_q.size() == 0);
    end

    in_valid <= 1'b0;
    wait (result_q.size() == 0);
    repeat (100) @(posedge clk);
    $display("Sent %0d characters; %0d tokens accepted, %0d rejected.",
             items_sent, tokens_ok, tokens_rej);
    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dtu_pkg.sv
rtl/dtu_div.sv
rtl/dtu_dp.sv
rtl/dtu_ctrl.sv
rtl/decimal_with_unit_to_integer.sv
test/tb.sv
